### sv/mecanum_encoder_odometry_defines.svh
// assertion macros for the mecanum odometry block
// expects clk_i and rst_ni in the scope of each use
`ifndef MECANUM_ENCODER_ODOMETRY_DEFINES_SVH
`define MECANUM_ENCODER_ODOMETRY_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MEO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define MEO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/meo_pkg.sv
// types, constants and tables for the mecanum odometry block
// no dependencies
package meo_pkg;

  localparam int CORDIC_STEPS   = 24;
  localparam int POSE_FRAC_BITS = 16;

  localparam int NSTEPS     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int DIST_SHIFT = 32 - POSE_FRAC_BITS;
  localparam int CHUNK_W    = 17;
  localparam int OPA_W      = 68;
  localparam int OPB_W      = 32;
  localparam int PROD_W     = CHUNK_W + OPB_W;
  localparam int ACC_W      = OPA_W + OPB_W;
  localparam int DMAG_W     = 66 - DIST_SHIFT;
  localparam int SUM_W      = 62;
  localparam int CORD_W     = 34;
  localparam int ITER_W     = 6;
  localparam int Q30        = 30;
  localparam int CNT_W      = 3;

  localparam logic [CNT_W-1:0]  NCH_SHORT   = 3'd2;
  localparam logic [CNT_W-1:0]  NCH_LONG    = 3'd4;
  localparam logic [CORD_W-1:0] CORDIC_GAIN = 34'd652032874;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN = 1'b1;

  typedef struct packed {
    logic               action;
    logic               reading_valid;
    logic signed [31:0] count_front_left;
    logic signed [31:0] count_front_right;
    logic signed [31:0] count_back_left;
    logic signed [31:0] count_back_right;
  } meo_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] heading;
  } meo_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_LOAD, ST_MUL, ST_POST, ST_CORDIC, ST_SAT, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_SX, OP_SY, OP_SR, OP_M0, OP_M1, OP_M2, OP_M3
  } mul_op_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      5'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/mecanum_encoder_odometry.sv
// mecanum wheel odometry: count deltas, kinematics, cordic rotation, pose update
// depends on meo_pkg and mecanum_encoder_odometry_defines.svh
//
// usage:
//   input channel (in_valid_i/in_ready_o/in_data_i) takes one word: an action bit,
//   a reading-valid bit and four raw encoder counts. output channel
//   (out_valid_o/out_ready_i/out_data_o) gives one pose word per input word.
//   cfg_we_i/cfg_idx_i/cfg_data_i write dist_per_count (0) and turn_per_count (1).
// timing:
//   a reset command or an invalid reading goes straight from idle to the output
//   state; out_valid_o rises once the output register is free. a valid reading
//   runs the sums, then three 2-chunk and four 4-chunk products through one 17x32
//   multiplier, one chunk a cycle, each product loaded, multiplied and then
//   post-processed, and the cordic rotator runs one step a cycle.
//   in_ready_o is high only while the sequencer is idle; one word at a time, so a
//   valid reading holds the block until its result enters the output register.
// reset: counts, pose, heading and both registers clear; no word pending.
// stall: the result waits in the output register; the next word is accepted
//   meanwhile, and its result waits for the register to empty.
`include "mecanum_encoder_odometry_defines.svh"

module mecanum_encoder_odometry (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  meo_pkg::meo_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output meo_pkg::meo_out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [meo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int SUM_W  = meo_pkg::SUM_W;
  localparam int CORD_W = meo_pkg::CORD_W;

  function automatic logic [33:0] abs35(input logic signed [34:0] v);
    logic [34:0] t;
    t = v[34] ? 35'(-v) : v;
    return t[33:0];
  endfunction

  function automatic logic [31:0] abs34(input logic signed [CORD_W-1:0] v);
    logic [CORD_W-1:0] t;
    t = v[CORD_W-1] ? CORD_W'(-v) : v;
    return t[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SUM_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  meo_pkg::state_e  state_q, state_d;
  meo_pkg::mul_op_e op_q;

  logic [31:0] dist_q, turn_q;
  logic [31:0] last_q [4];
  logic [31:0] d_q [4];
  logic [31:0] cnt_in [4];
  logic signed [34:0] sx_q, sy_q, sr_q;

  logic [meo_pkg::OPA_W-1:0]   a_q;
  logic [meo_pkg::OPB_W-1:0]   b_q;
  logic                        neg_q;
  logic [meo_pkg::CNT_W-1:0]   nch_q, cnt_q;
  logic [meo_pkg::PROD_W-1:0]  prod_q;
  logic [1:0]                  pidx_q;
  logic                        pv_q;
  logic [meo_pkg::ACC_W-1:0]   acc_q;

  logic [meo_pkg::DMAG_W-1:0]  dxr_mag_q, dyr_mag_q;
  logic                        dxr_neg_q, dyr_neg_q;
  logic [31:0]                 step_q;
  logic signed [CORD_W-1:0]    cx_q, cy_q, cz_q;
  logic                        flip_q;
  logic [meo_pkg::ITER_W-1:0]  iter_q;
  logic signed [SUM_W-1:0]     sum_x_q, sum_y_q;
  logic [31:0]                 pos_x_q, pos_y_q, head_q;
  meo_pkg::meo_out_t           out_q;
  logic                        out_valid_q;

  logic in_fire, out_free;

  assign in_ready_o  = (state_q == meo_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_in[0] = in_data_i.count_front_left;
  assign cnt_in[1] = in_data_i.count_front_right;
  assign cnt_in[2] = in_data_i.count_back_left;
  assign cnt_in[3] = in_data_i.count_back_right;

  // kinematic sums from the stored deltas
  logic signed [34:0] e0, e1, e2, e3;
  assign e0 = {{3{d_q[0][31]}}, d_q[0]};
  assign e1 = {{3{d_q[1][31]}}, d_q[1]};
  assign e2 = {{3{d_q[2][31]}}, d_q[2]};
  assign e3 = {{3{d_q[3][31]}}, d_q[3]};

  // shared multiplier: one 17-bit chunk of a times b per cycle
  logic [meo_pkg::CHUNK_W-1:0] chunk_w;
  logic [meo_pkg::PROD_W-1:0]  mul_w;
  logic [meo_pkg::ACC_W-1:0]   acc_add;
  assign chunk_w = meo_pkg::CHUNK_W'(a_q >> (meo_pkg::CHUNK_W * cnt_q[1:0]));
  assign mul_w   = meo_pkg::PROD_W'(chunk_w) * meo_pkg::PROD_W'(b_q);
  assign acc_add = acc_q + (meo_pkg::ACC_W'(prod_q) << (meo_pkg::CHUNK_W * pidx_q));

  // operand selection for the next product
  logic [31:0]               cs_mag, sn_mag;
  logic                      cs_neg, sn_neg;
  logic [meo_pkg::OPA_W-1:0] ld_a;
  logic [meo_pkg::OPB_W-1:0] ld_b;
  logic                      ld_neg;
  logic [meo_pkg::CNT_W-1:0] ld_nch;

  assign cs_mag = abs34(cx_q);
  assign sn_mag = abs34(cy_q);
  assign cs_neg = cx_q[CORD_W-1] ^ flip_q;
  assign sn_neg = cy_q[CORD_W-1] ^ flip_q;

  always_comb begin
    ld_a   = '0;
    ld_b   = '0;
    ld_neg = 1'b0;
    ld_nch = meo_pkg::NCH_LONG;
    case (op_q)
      meo_pkg::OP_SX: begin
        ld_a = meo_pkg::OPA_W'(abs35(sx_q)); ld_b = dist_q; ld_neg = sx_q[34];
        ld_nch = meo_pkg::NCH_SHORT;
      end
      meo_pkg::OP_SY: begin
        ld_a = meo_pkg::OPA_W'(abs35(sy_q)); ld_b = dist_q; ld_neg = sy_q[34];
        ld_nch = meo_pkg::NCH_SHORT;
      end
      meo_pkg::OP_SR: begin
        ld_a = meo_pkg::OPA_W'(abs35(sr_q)); ld_b = turn_q; ld_neg = sr_q[34];
        ld_nch = meo_pkg::NCH_SHORT;
      end
      meo_pkg::OP_M0: begin
        ld_a = meo_pkg::OPA_W'(dxr_mag_q); ld_b = cs_mag; ld_neg = dxr_neg_q ^ cs_neg;
      end
      meo_pkg::OP_M1: begin
        ld_a = meo_pkg::OPA_W'(dyr_mag_q); ld_b = sn_mag; ld_neg = dyr_neg_q ^ sn_neg;
      end
      meo_pkg::OP_M2: begin
        ld_a = meo_pkg::OPA_W'(dxr_mag_q); ld_b = sn_mag; ld_neg = dxr_neg_q ^ sn_neg;
      end
      meo_pkg::OP_M3: begin
        ld_a = meo_pkg::OPA_W'(dyr_mag_q); ld_b = cs_mag; ld_neg = dyr_neg_q ^ cs_neg;
      end
      default: ld_a = '0;
    endcase
  end

  // results taken from the accumulator
  logic [meo_pkg::DMAG_W-1:0] dmag_w;
  logic [40:0]                p41;
  logic [31:0]                theta_w, theta_f;
  logic                       fold_w;
  logic signed [SUM_W-1:0]    m_w, m_s;

  assign dmag_w  = meo_pkg::DMAG_W'(acc_q >> meo_pkg::DIST_SHIFT);
  assign p41     = neg_q ? 41'(-acc_q[40:0]) : acc_q[40:0];
  assign theta_w = head_q + p41[40:9];
  // angles in the left half are turned by half a turn, result negated later
  assign fold_w  = theta_w[31] ^ theta_w[30];
  assign theta_f = {theta_w[31] ^ fold_w, theta_w[30:0]};
  assign m_w     = SUM_W'(acc_q >> meo_pkg::Q30);
  assign m_s     = neg_q ? SUM_W'(-m_w) : m_w;

  // cordic rotation step
  logic [4:0]               idx_w;
  logic signed [CORD_W-1:0] xs_w, ys_w, at_w;
  assign idx_w = iter_q[4:0];
  assign xs_w  = cx_q >>> idx_w;
  assign ys_w  = cy_q >>> idx_w;
  assign at_w  = {2'b00, meo_pkg::atan_lut(idx_w)};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      meo_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.action || !in_data_i.reading_valid) begin
            state_d = meo_pkg::ST_OUT;
          end else begin
            state_d = meo_pkg::ST_SUM;
          end
        end
      end
      meo_pkg::ST_SUM:  state_d = meo_pkg::ST_LOAD;
      meo_pkg::ST_LOAD: state_d = meo_pkg::ST_MUL;
      meo_pkg::ST_MUL: begin
        if (cnt_q == nch_q) state_d = meo_pkg::ST_POST;
      end
      meo_pkg::ST_POST: begin
        case (op_q)
          meo_pkg::OP_SR: state_d = meo_pkg::ST_CORDIC;
          meo_pkg::OP_M3: state_d = meo_pkg::ST_SAT;
          default:        state_d = meo_pkg::ST_LOAD;
        endcase
      end
      meo_pkg::ST_CORDIC: begin
        if (iter_q == meo_pkg::ITER_W'(meo_pkg::NSTEPS - 1)) state_d = meo_pkg::ST_LOAD;
      end
      meo_pkg::ST_SAT: state_d = meo_pkg::ST_OUT;
      meo_pkg::ST_OUT: begin
        if (out_free) state_d = meo_pkg::ST_IDLE;
      end
      default: state_d = meo_pkg::ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= meo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      turn_q      <= '0;
      for (int i = 0; i < 4; i++) last_q[i] <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          meo_pkg::REG_DIST: dist_q <= cfg_data_i;
          meo_pkg::REG_TURN: turn_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        if (in_data_i.action) begin
          for (int i = 0; i < 4; i++) last_q[i] <= '0;
          pos_x_q <= '0;
          pos_y_q <= '0;
          head_q  <= '0;
        end else if (in_data_i.reading_valid) begin
          for (int i = 0; i < 4; i++) last_q[i] <= cnt_in[i];
        end
      end
      if (state_q == meo_pkg::ST_SAT) begin
        pos_x_q <= sat32(sum_x_q);
        pos_y_q <= sat32(sum_y_q);
        head_q  <= head_q + step_q;
      end
      if (state_q == meo_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      meo_pkg::ST_IDLE: begin
        if (in_fire) begin
          for (int i = 0; i < 4; i++) d_q[i] <= cnt_in[i] - last_q[i];
        end
      end
      meo_pkg::ST_SUM: begin
        sx_q    <= -e0 + e1 + e2 - e3;
        sy_q    <= e0 + e1 + e2 + e3;
        sr_q    <= -e0 + e1 - e2 + e3;
        op_q    <= meo_pkg::OP_SX;
        sum_x_q <= {{(SUM_W-32){pos_x_q[31]}}, pos_x_q};
        sum_y_q <= {{(SUM_W-32){pos_y_q[31]}}, pos_y_q};
      end
      meo_pkg::ST_LOAD: begin
        a_q   <= ld_a;
        b_q   <= ld_b;
        neg_q <= ld_neg;
        nch_q <= ld_nch;
        cnt_q <= '0;
        pv_q  <= 1'b0;
        acc_q <= '0;
      end
      meo_pkg::ST_MUL: begin
        if (cnt_q != nch_q) begin
          prod_q <= mul_w;
          pidx_q <= cnt_q[1:0];
          pv_q   <= 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          pv_q <= 1'b0;
        end
        if (pv_q) acc_q <= acc_add;
      end
      meo_pkg::ST_POST: begin
        case (op_q)
          meo_pkg::OP_SX: begin
            dxr_mag_q <= dmag_w; dxr_neg_q <= neg_q; op_q <= meo_pkg::OP_SY;
          end
          meo_pkg::OP_SY: begin
            dyr_mag_q <= dmag_w; dyr_neg_q <= neg_q; op_q <= meo_pkg::OP_SR;
          end
          meo_pkg::OP_SR: begin
            step_q <= p41[39:8];
            cx_q   <= meo_pkg::CORDIC_GAIN;
            cy_q   <= '0;
            cz_q   <= {{(CORD_W-32){theta_f[31]}}, theta_f};
            flip_q <= fold_w;
            iter_q <= '0;
            op_q   <= meo_pkg::OP_M0;
          end
          meo_pkg::OP_M0: begin
            sum_x_q <= sum_x_q - m_s; op_q <= meo_pkg::OP_M1;
          end
          meo_pkg::OP_M1: begin
            sum_x_q <= sum_x_q + m_s; op_q <= meo_pkg::OP_M2;
          end
          meo_pkg::OP_M2: begin
            sum_y_q <= sum_y_q + m_s; op_q <= meo_pkg::OP_M3;
          end
          meo_pkg::OP_M3: begin
            sum_y_q <= sum_y_q + m_s;
          end
          default: ;
        endcase
      end
      meo_pkg::ST_CORDIC: begin
        iter_q <= iter_q + 1'b1;
        if (!cz_q[CORD_W-1]) begin
          cx_q <= cx_q - ys_w; cy_q <= cy_q + xs_w; cz_q <= cz_q - at_w;
        end else begin
          cx_q <= cx_q + ys_w; cy_q <= cy_q - xs_w; cz_q <= cz_q + at_w;
        end
      end
      meo_pkg::ST_OUT: begin
        if (out_free) begin
          out_q.pose_x  <= pos_x_q;
          out_q.pose_y  <= pos_y_q;
          out_q.heading <= head_q;
        end
      end
      default: ;
    endcase
  end

  `MEO_ASSERT_NEXT(a_update_starts, in_fire && !in_data_i.action && in_data_i.reading_valid, state_q == meo_pkg::ST_SUM, "valid update did not start the sequence")
  `MEO_ASSERT(a_chunk_bound, state_q == meo_pkg::ST_MUL, cnt_q <= nch_q, "multiplier chunk count overran")
  `MEO_ASSERT(a_cordic_bound, state_q == meo_pkg::ST_CORDIC, iter_q < meo_pkg::ITER_W'(meo_pkg::NSTEPS), "cordic step count overran")
  `MEO_ASSERT_NEXT(a_reset_clears, in_fire && in_data_i.action, pos_x_q == '0 && pos_y_q == '0 && head_q == '0, "reset command left pose set")

endmodule
